@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle, outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle, checked through reset too.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/yuv2rgb_pkg.sv @@
package yuv2rgb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SCALE_NUM   = 220;
  localparam int SCALE_SHIFT = 8;
  localparam int PROD_W      = 27;
  localparam int SUM_W       = 28;
  localparam int COLOUR_MAX  = (255 * SCALE_NUM) >> SCALE_SHIFT;

  // Q1.16 coefficients, rounded to nearest
  localparam logic [16:0] COEF_R_V = 17'd89831;
  localparam logic [16:0] COEF_G_V = 17'd45744;
  localparam logic [16:0] COEF_G_U = 17'd22127;
  localparam logic [16:0] COEF_B_U = 17'd113538;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end;
  } yuyv_word_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;
  } rgb_word_t;

  // after the chroma multipliers
  typedef struct packed {
    logic [7:0]               luma_first;
    logic [7:0]               luma_second;
    logic signed [PROD_W-1:0] prod_rv;
    logic signed [PROD_W-1:0] prod_gv;
    logic signed [PROD_W-1:0] prod_gu;
    logic signed [PROD_W-1:0] prod_bu;
    logic                     frame_end;
  } prod_word_t;

  // after the per-pixel sums
  typedef struct packed {
    logic signed [SUM_W-1:0] red_first;
    logic signed [SUM_W-1:0] green_first;
    logic signed [SUM_W-1:0] blue_first;
    logic signed [SUM_W-1:0] red_second;
    logic signed [SUM_W-1:0] green_second;
    logic signed [SUM_W-1:0] blue_second;
    logic                    frame_end;
  } sum_word_t;

endpackage

@@ rtl/yuv2rgb_chroma.sv @@
module yuv2rgb_chroma (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  yuv2rgb_pkg::yuyv_word_t in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output yuv2rgb_pkg::prod_word_t out_word
);
  import yuv2rgb_pkg::*;

  localparam logic signed [PROD_W-1:0] K_RV = PROD_W'(COEF_R_V);
  localparam logic signed [PROD_W-1:0] K_GV = PROD_W'(COEF_G_V);
  localparam logic signed [PROD_W-1:0] K_GU = PROD_W'(COEF_G_U);
  localparam logic signed [PROD_W-1:0] K_BU = PROD_W'(COEF_B_U);

  logic signed [PROD_W-1:0] du;
  logic signed [PROD_W-1:0] dv;
  prod_word_t               word_next;

  // x - 128 for an 8-bit x is x with its top bit inverted, read as signed
  always_comb begin
    du = PROD_W'($signed({~in_word.chroma_blue[7], in_word.chroma_blue[6:0]}));
    dv = PROD_W'($signed({~in_word.chroma_red[7], in_word.chroma_red[6:0]}));
    word_next.luma_first  = in_word.luma_first;
    word_next.luma_second = in_word.luma_second;
    word_next.prod_rv     = K_RV * dv;
    word_next.prod_gv     = K_GV * dv;
    word_next.prod_gu     = K_GU * du;
    word_next.prod_bu     = K_BU * du;
    word_next.frame_end   = in_word.frame_end;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

@@ rtl/yuv2rgb_sum.sv @@
module yuv2rgb_sum (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  yuv2rgb_pkg::prod_word_t in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output yuv2rgb_pkg::sum_word_t  out_word
);
  import yuv2rgb_pkg::*;

  logic signed [SUM_W-1:0] base0;
  logic signed [SUM_W-1:0] base1;
  logic signed [SUM_W-1:0] rv;
  logic signed [SUM_W-1:0] gvu;
  logic signed [SUM_W-1:0] bu;
  sum_word_t               word_next;

  always_comb begin
    base0 = SUM_W'($signed({1'b0, in_word.luma_first, {FRAC_BITS{1'b0}}}));
    base1 = SUM_W'($signed({1'b0, in_word.luma_second, {FRAC_BITS{1'b0}}}));
    rv    = SUM_W'(in_word.prod_rv);
    gvu   = SUM_W'(in_word.prod_gv) + SUM_W'(in_word.prod_gu);
    bu    = SUM_W'(in_word.prod_bu);
    word_next.red_first    = base0 + rv;
    word_next.green_first  = base0 - gvu;
    word_next.blue_first   = base0 + bu;
    word_next.red_second   = base1 + rv;
    word_next.green_second = base1 - gvu;
    word_next.blue_second  = base1 + bu;
    word_next.frame_end    = in_word.frame_end;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

@@ rtl/yuv2rgb_scale.sv @@
module yuv2rgb_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  yuv2rgb_pkg::sum_word_t in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output yuv2rgb_pkg::rgb_word_t out_word
);
  import yuv2rgb_pkg::*;

  localparam logic [7:0] K_SCALE = 8'(SCALE_NUM);

  rgb_word_t word_next;

  // negative -> 0, integer part saturated at 255, then * 220 >> 8
  function automatic logic [7:0] clamp_scale(input logic signed [SUM_W-1:0] s);
    logic [7:0]  c;
    logic [15:0] p;
    if (s[SUM_W-1]) begin
      c = 8'd0;
    end else if (|s[SUM_W-2:FRAC_BITS+8]) begin
      c = 8'hff;
    end else begin
      c = s[FRAC_BITS+7:FRAC_BITS];
    end
    p = 16'(c) * 16'(K_SCALE);
    return p[15:SCALE_SHIFT];
  endfunction

  always_comb begin
    word_next.red_first     = clamp_scale(in_word.red_first);
    word_next.green_first   = clamp_scale(in_word.green_first);
    word_next.blue_first    = clamp_scale(in_word.blue_first);
    word_next.red_second    = clamp_scale(in_word.red_second);
    word_next.green_second  = clamp_scale(in_word.green_second);
    word_next.blue_second   = clamp_scale(in_word.blue_second);
    word_next.frame_end_out = in_word.frame_end;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

@@ rtl/yuv2rgb_converter_top.sv @@
// YUYV 4:2:2 to RGB888 converter, one pixel pair per word.
//
// Input channel (yuyv_valid / yuyv_ready / yuyv): one word per YUYV group,
// Y0, U, Y1, V and a last-of-frame flag. Output channel (rgb_valid /
// rgb_ready / rgb): two RGB pixels sharing the chroma, each colour clamped
// to 0..255 and scaled by 220/256, so 0..219; the frame flag rides along.
//
// Three register stages: chroma multipliers, per-pixel sums, clamp and
// scale. An accepted word passes through them in that order before it
// shows on rgb; throughput is one word per clock while the receiver
// keeps rgb_ready high.
//
// Each stage holds its own valid bit and loads when it is empty or its
// successor moves, so bubbles are squeezed out. When the receiver stalls
// the stages fill up in turn; yuyv_ready falls only once all three hold a
// word. Nothing is dropped or repeated.
//
// Reset (rst, synchronous) clears the valid bits only; the data registers
// are not reset. yuyv_ready is high once reset has emptied the stages, so
// a word can be taken as soon as rst falls.
module yuyv_to_rgb_converter_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    yuyv_valid,
  output logic                    yuyv_ready,
  input  yuv2rgb_pkg::yuyv_word_t yuyv,
  output logic                    rgb_valid,
  input  logic                    rgb_ready,
  output yuv2rgb_pkg::rgb_word_t  rgb
);
  import yuv2rgb_pkg::*;
  `include "assert_macros.svh"

  prod_word_t prod_word;
  sum_word_t  sum_word;
  logic       prod_valid;
  logic       prod_ready;
  logic       sum_valid;
  logic       sum_ready;

  // stage 1: shared chroma products
  yuv2rgb_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yuyv_valid),
    .in_ready  (yuyv_ready),
    .in_word   (yuyv),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_word  (prod_word)
  );

  // stage 2: Q.16 sums, six of them
  yuv2rgb_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_word   (prod_word),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_word  (sum_word)
  );

  // stage 3: clamp, scale, output register
  yuv2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_word   (sum_word),
    .out_valid (rgb_valid),
    .out_ready (rgb_ready),
    .out_word  (rgb)
  );

  // input is held off only with the whole pipe full and the output stalled
  `ASSERT_IMPLIES(a_full_stall, clk, rst, !yuyv_ready,
                  prod_valid && sum_valid && rgb_valid && !rgb_ready)
  // scaled colours stay within range
  `ASSERT_IMPLIES(a_range, clk, rst, rgb_valid,
                  rgb.red_first <= 8'(COLOUR_MAX) && rgb.green_first <= 8'(COLOUR_MAX) &&
                  rgb.blue_first <= 8'(COLOUR_MAX) && rgb.red_second <= 8'(COLOUR_MAX) &&
                  rgb.green_second <= 8'(COLOUR_MAX) && rgb.blue_second <= 8'(COLOUR_MAX))
  // reset empties every stage
  `ASSERT_NEXT(a_reset_empty, clk, rst, !prod_valid && !sum_valid && !rgb_valid)

endmodule
